// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/hcb_pkg.sv =====
// Command and status types between the Huffman builder controller and datapath
package hcb_pkg;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic merge_lo;
    logic merge_hi;
    logic merge_new;
    logic walk_start;
    logic walk_req;
    logic walk_dat;
  } cmd_t;

  typedef struct packed {
    logic set_small;
    logic scan_done;
    logic last_merge;
    logic leaf_done;
    logic last_leaf;
  } status_t;

endpackage

// ===== rtl/core/hcb_ram.sv =====
// Generic single write port RAM with registered read
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/hcb_ctrl.sv =====
// Controller state machine for the Huffman code builder
module hcb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             last,
  input  hcb_pkg::status_t st,
  output hcb_pkg::cmd_t    cmd,
  output logic             busy
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_MLO, S_MHI, S_MNEW, S_WREQ, S_WDAT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.load = start;
        if (start && last && !st.set_small) begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) begin
          state_next = S_MLO;
        end
      end
      S_MLO: begin
        cmd.merge_lo = 1'b1;
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.merge_hi = 1'b1;
        state_next = S_MNEW;
      end
      S_MNEW: begin
        cmd.merge_new = 1'b1;
        if (st.last_merge) begin
          cmd.walk_start = 1'b1;
          state_next = S_WREQ;
        end else begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_WREQ: begin
        cmd.walk_req = 1'b1;
        state_next = S_WDAT;
      end
      S_WDAT: begin
        cmd.walk_dat = 1'b1;
        state_next = (st.leaf_done && st.last_leaf) ? S_IDLE : S_WREQ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/core/hcb_datapath.sv =====
// Node store, minimum search, merge writes and code walk for the Huffman builder
module hcb_datapath #(
  parameter int MAX_SYMBOLS = 32,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hcb_pkg::cmd_t          cmd,
  output hcb_pkg::status_t       st,
  input  logic [WEIGHT_BITS-1:0] weight,
  input  logic                   last,
  output logic                   done,
  output logic [4:0]             symbol_index,
  output logic [30:0]            code_bits,
  output logic [4:0]             code_length,
  output logic                   last_res
);

  localparam int NN = 2 * MAX_SYMBOLS - 1;
  localparam int PW = $clog2(NN);
  localparam int CW = $clog2(MAX_SYMBOLS + 1);
  localparam int SW = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
  localparam int DW = SW + PW + 1;

  logic [CW-1:0] count, n;
  logic [PW-1:0] used, addr, ridx, ca, cb, leaf, p, len;
  logic [SW-1:0] wa, wb;
  logic [1:0]    nfound;
  logic          rv;
  logic [30:0]   code;

  logic          we;
  logic [PW-1:0] waddr, raddr, root, lo, hi;
  logic [DW-1:0] wdata, rdata;
  logic [SW-1:0] rw, top, wlo, whi;
  logic [PW-1:0] rpar;
  logic          rleft, store;
  logic [CW-1:0] count_after;
  logic [30:0]   code_next;

  assign rw    = rdata[DW-1 -: SW];
  assign rpar  = rdata[PW:1];
  assign rleft = rdata[0];
  assign root  = PW'({n, 1'b0} - 2);
  assign store = (count < CW'(MAX_SYMBOLS));
  assign count_after = store ? count + CW'(1) : count;
  assign top = (wa > wb) ? wa : wb;
  assign lo  = (ca < cb) ? ca : cb;
  assign hi  = (ca < cb) ? cb : ca;
  assign wlo = (ca < cb) ? wa : wb;
  assign whi = (ca < cb) ? wb : wa;
  assign code_next = code | ((!rleft && int'(len) < 31) ? (31'(1) << len) : 31'(0));

  assign st.set_small  = (count_after <= CW'(1));
  assign st.scan_done  = (addr == used) && !rv;
  assign st.last_merge = (used == root);
  assign st.leaf_done  = (rpar == root);
  assign st.last_leaf  = (leaf == PW'(n - CW'(1)));

  always_comb begin
    we = 1'b0;
    waddr = used;
    wdata = '0;
    if (cmd.load) begin
      we = store;
      waddr = PW'(count);
      wdata = {SW'(weight), PW'(0), 1'b0};
    end else if (cmd.merge_lo) begin
      we = 1'b1;
      waddr = lo;
      wdata = {wlo, used, 1'b1};
    end else if (cmd.merge_hi) begin
      we = 1'b1;
      waddr = hi;
      wdata = {whi, used, 1'b0};
    end else if (cmd.merge_new) begin
      we = 1'b1;
      wdata = {wa + wb, PW'(0), 1'b0};
    end
  end

  assign raddr = cmd.walk_req ? p : addr;

  hcb_ram #(.WIDTH(DW), .DEPTH(NN)) u_nodes (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
      rv    <= 1'b0;
    end else begin
      done <= (cmd.load && last && (count_after <= CW'(1))) ||
              (cmd.walk_dat && st.leaf_done);
      if (cmd.load) begin
        count <= last ? '0 : count_after;
        if (last) begin
          n     <= count_after;
          used  <= PW'(count_after);
          if (count_after <= CW'(1)) begin
            symbol_index <= '0;
            code_bits    <= 31'(1);
            code_length  <= 5'd1;
            last_res     <= 1'b1;
          end
        end
      end
      if (cmd.scan_start) begin
        addr   <= '0;
        nfound <= '0;
        rv     <= 1'b0;
      end
      if (cmd.scan_step) begin
        rv <= (addr < used);
        if (addr < used) begin
          ridx <= addr;
          addr <= addr + PW'(1);
        end
        if (rv && rpar == '0) begin
          if (nfound == 2'd0) begin
            ca <= ridx;
            wa <= rw;
            nfound <= 2'd1;
          end else if (nfound == 2'd1) begin
            cb <= ridx;
            wb <= rw;
            nfound <= 2'd2;
          end else if (rw < top) begin
            if ((wa != wb) ? (wa > wb) : (ca > cb)) begin
              ca <= ridx;
              wa <= rw;
            end else begin
              cb <= ridx;
              wb <= rw;
            end
          end
        end
      end
      if (cmd.merge_new) begin
        used <= used + PW'(1);
      end
      if (cmd.walk_start) begin
        leaf <= '0;
        p    <= '0;
        len  <= '0;
        code <= '0;
      end
      if (cmd.walk_dat) begin
        if (st.leaf_done) begin
          symbol_index <= 5'(leaf);
          code_bits    <= code_next;
          code_length  <= 5'(len + PW'(1));
          last_res     <= st.last_leaf;
          leaf <= leaf + PW'(1);
          p    <= leaf + PW'(1);
          len  <= '0;
          code <= '0;
        end else begin
          p    <= rpar;
          len  <= len + PW'(1);
          code <= code_next;
        end
      end
    end
  end

endmodule

// ===== rtl/core/huffman_code_builder.sv =====
// Huffman code builder top level: controller plus node datapath
//
//  channel   handshake          fields
//  input     start / busy       weight, last
//  result    done (strobe)      symbol_index, code_bits, code_length, last_res
//
// An item without last is taken while idle. A closing item of n symbols runs n-1
// merges, each a scan of the used nodes through the one node RAM read port plus
// writes in states S_MLO, S_MHI and S_MNEW, then a walk of a request and a data
// state per tree level for each symbol. A set of one symbol answers in the next
// cycle. Reset is synchronous; results are never stalled.
`include "assert_macros.svh"

module huffman_code_builder #(
  parameter int MAX_SYMBOLS = 32,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [WEIGHT_BITS-1:0] weight,
  input  logic                   last,
  output logic                   done,
  output logic [4:0]             symbol_index,
  output logic [30:0]            code_bits,
  output logic [4:0]             code_length,
  output logic                   last_res
);

  hcb_pkg::cmd_t    cmd;
  hcb_pkg::status_t st;

  hcb_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .last (last),
    .st   (st),
    .cmd  (cmd),
    .busy (busy)
  );

  hcb_datapath #(.MAX_SYMBOLS(MAX_SYMBOLS), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .weight      (weight),
    .last        (last),
    .done        (done),
    .symbol_index(symbol_index),
    .code_bits   (code_bits),
    .code_length (code_length),
    .last_res    (last_res)
  );

  `ASSERT_IMPLY(a_final_idle, clk, rst, done && last_res, !busy)
  `ASSERT_IMPLY(a_mid_busy, clk, rst, done && !last_res, busy)
  `ASSERT_NEXT(a_no_res_plain, clk, rst, start && !busy && !last, !done)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the Huffman code builder: random weight sets, code check per symbol
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SYM = 32;
  localparam int SLOTS = 2 * MAX_SYM - 1;

  typedef struct packed {
    logic [15:0] w;
    logic        lst;
  } weight_item_t;

  typedef struct packed {
    logic [4:0]  idx;
    logic [30:0] code;
    logic [4:0]  len;
    logic        lst;
  } code_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [15:0] weight = '0;
  logic        last = 0;
  logic        done;
  logic [4:0]  symbol_index;
  logic [30:0] code_bits;
  logic [4:0]  code_length;
  logic        last_res;

  huffman_code_builder dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .weight(weight), .last(last),
    .done(done), .symbol_index(symbol_index), .code_bits(code_bits),
    .code_length(code_length), .last_res(last_res)
  );

  always #1 clk = ~clk;

  weight_item_t pending[$];
  code_t        expected_codes[$];
  int           errors = 0;
  bit           calm = 0;

  // predictor state
  logic [20:0] nw[SLOTS];
  int          np[SLOTS];
  bit          nl[SLOTS];
  int          sym_cnt = 0;

  function automatic void enqueue(weight_item_t it);
    pending.insert(pending.size(), it);
  endfunction

  function automatic void build_codes(weight_item_t it);
    int n, used, a, b, i, p, len, guard, t, root;
    logic [20:0] wa, wb, top;
    logic [63:0] code;
    code_t r;
    if (sym_cnt < MAX_SYM) begin
      nw[sym_cnt] = 21'(it.w);
      np[sym_cnt] = 0;
      nl[sym_cnt] = 0;
      sym_cnt++;
    end
    if (!it.lst) return;
    n = sym_cnt;
    sym_cnt = 0;
    if (n <= 1) begin
      r = '{5'd0, 31'd1, 5'd1, 1'b1};
      expected_codes.insert(expected_codes.size(), r);
      return;
    end
    for (i = 0; i < n; i++) begin
      np[i] = 0;
      nl[i] = 0;
    end
    used = n;
    while (used < 2 * n - 1) begin
      i = 0;
      while (i < used && np[i] != 0) i++;
      a = i;
      i++;
      while (i < used && np[i] != 0) i++;
      b = i;
      i++;
      while (i < used) begin
        wa = nw[a];
        wb = nw[b];
        top = wa > wb ? wa : wb;
        if (np[i] == 0 && nw[i] < top) begin
          if (wa != wb) begin
            if (wa > wb) a = i; else b = i;
          end else begin
            if (a > b) a = i; else b = i;
          end
        end
        i++;
      end
      if (a > b) begin
        t = a; a = b; b = t;
      end
      np[a] = used;
      np[b] = used;
      nl[a] = 1;
      nl[b] = 0;
      nw[used] = nw[a] + nw[b];
      np[used] = 0;
      nl[used] = 0;
      used++;
    end
    root = 2 * n - 2;
    for (i = 0; i < n; i++) begin
      p = i;
      len = 0;
      guard = 0;
      code = '0;
      do begin
        if (!nl[p] && len < 64) code[len] = 1'b1;
        len++;
        p = np[p];
        guard++;
      end while (p != root && p < SLOTS && guard < SLOTS);
      r.idx = 5'(i);
      r.code = code[30:0];
      r.len = 5'(len);
      r.lst = (i == n - 1);
      expected_codes.insert(expected_codes.size(), r);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        build_codes('{weight, last});
        if (pending.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
          weight <= pending[0].w;
          last <= pending[0].lst;
          void'(pending.pop_front());
        end else begin
          start <= 1'b0;
        end
      end else if (!start && pending.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
        start <= 1'b1;
        weight <= pending[0].w;
        last <= pending[0].lst;
        void'(pending.pop_front());
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    code_t e;
    if (!rst && done) begin
      if (expected_codes.size() == 0) begin
        $error("unexpected result idx=%0d", symbol_index);
        errors++;
      end else begin
        e = expected_codes.pop_front();
        if (symbol_index !== e.idx) begin
          $error("symbol_index exp %0d got %0d", e.idx, symbol_index); errors++;
        end
        if (code_bits !== e.code) begin
          $error("code_bits exp %h got %h", e.code, code_bits); errors++;
        end
        if (code_length !== e.len) begin
          $error("code_length exp %0d got %0d", e.len, code_length); errors++;
        end
        if (last_res !== e.lst) begin
          $error("last_res exp %0d got %0d", e.lst, last_res); errors++;
        end
      end
    end
  end

  task automatic add_set(int n, int mode);
    weight_item_t it;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: it.w = 16'($urandom);
        1: it.w = 16'($urandom_range(3));
        2: it.w = 16'hFFFF;
        3: it.w = 16'(1 << (i % 16));
        default: it.w = 16'($urandom_range(20));
      endcase
      it.lst = (i == n - 1);
      enqueue(it);
    end
  endtask

  initial begin
    int total;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    add_set(1, 0);
    add_set(2, 2);
    enqueue('{16'h0000, 1'b0});
    enqueue('{16'h0000, 1'b1});
    add_set(3, 1);
    add_set(17, 3);
    // overflow: 35 weights into 32 slots
    add_set(35, 0);
    add_set(32, 2);
    total = 0;
    while (total < 18) begin
      int n;
      n = $urandom_range(8, 1);
      add_set(n, $urandom_range(4));
      total += n;
      if ($urandom_range(4) == 0) enqueue('{16'($urandom), 1'b0});
    end
    while (pending.size() >= 80) @(posedge clk);
    calm = 1;
    while (pending.size() >= 40) @(posedge clk);
    calm = 0;
    while (pending.size() != 0 || start) @(posedge clk);
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("huffman_code_builder verification clean");
    else $display("huffman_code_builder verification failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("huffman_code_builder verification failed");
    $finish;
  end
endmodule
